[rtl/gtb_pkg.sv]
// ----------------------------------------------------------------------------
// gtb_pkg
// Shared sizes, register indexes and types of the two-border flood block.
// ----------------------------------------------------------------------------
package gtb_pkg;

  localparam int MAX_ROWS    = 32;
  localparam int MAX_COLS    = 32;
  localparam int HEIGHT_BITS = 16;

  localparam int RB = $clog2(MAX_ROWS);
  localparam int CB = $clog2(MAX_COLS);
  localparam int AW = RB + CB;

  localparam int SZ_W      = 6;
  localparam int CFG_IDX_W = 2;
  localparam int ROW_W     = 5;
  localparam int TDATA_O_W = 40;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COLS = CFG_IDX_W'(1);

  localparam logic [SZ_W-1:0] SIZE_RESET = SZ_W'(32);

  typedef struct packed {
    logic [SZ_W-1:0] nr;
    logic [SZ_W-1:0] nc;
    logic            restart;
  } size_t;

  typedef struct packed {
    logic [ROW_W-1:0]    row;
    logic [MAX_COLS-1:0] mask;
    logic                last;
  } result_t;

  // zero reads as one, oversize saturates
  function automatic logic [SZ_W-1:0] eff_size(logic [SZ_W-1:0] v, logic [SZ_W-1:0] maxv);
    logic [SZ_W-1:0] r;
    r = v;
    if (v == '0) r = SZ_W'(1);
    else if (v > maxv) r = maxv;
    return r;
  endfunction

endpackage

[rtl/gtb_ram.sv]
// ----------------------------------------------------------------------------
// gtb_ram
// Generic single-port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module gtb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    if (re_i) rdata_o <= mem[addr_i];
  end

endmodule

[rtl/gtb_engine.sv]
// ----------------------------------------------------------------------------
// gtb_engine
// Grid load, per-flood mark clearing, queue-driven floods and row read-out.
// ----------------------------------------------------------------------------
module gtb_engine
  import gtb_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  size_t                  size_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [HEIGHT_BITS-1:0] in_height_i,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output result_t                res_o
);

  typedef enum logic [3:0] {
    S_LOAD, S_CLR, S_SEED_R, S_SEED_W, S_POP, S_POP_W, S_HGT_W,
    S_NB_R, S_NB_W, S_OUT_R, S_OUT_W
  } state_e;

  state_e state_q;
  logic                   f_q;
  logic [RB-1:0]          lr_q;
  logic [CB-1:0]          lc_q;
  logic [SZ_W:0]          cnt_q;
  logic [AW:0]            head_q, tail_q;
  logic [AW-1:0]          cur_q;
  logic [HEIGHT_BITS-1:0] h_q;
  logic [RB-1:0]          tr_q;
  logic [CB-1:0]          tc_q;
  logic [1:0]             d_q;

  // memory ports
  logic [AW-1:0]          h_addr, q_addr;
  logic                   h_we, h_re, q_we, q_re;
  logic [HEIGHT_BITS-1:0] h_wd, h_rd;
  logic [AW-1:0]          q_wd, q_rd;
  logic [RB-1:0]          m_addr;
  logic                   m_re, m0_we, m1_we;
  logic [MAX_COLS-1:0]    m_wd, m0_rd, m1_rd, mrow;

  gtb_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(2**AW)) u_height (
    .clk_i, .addr_i(h_addr), .we_i(h_we), .re_i(h_re), .wdata_i(h_wd), .rdata_o(h_rd));
  gtb_ram #(.WIDTH(AW), .DEPTH(2**AW)) u_queue (
    .clk_i, .addr_i(q_addr), .we_i(q_we), .re_i(q_re), .wdata_i(q_wd), .rdata_o(q_rd));
  gtb_ram #(.WIDTH(MAX_COLS), .DEPTH(2**RB)) u_mark0 (
    .clk_i, .addr_i(m_addr), .we_i(m0_we), .re_i(m_re), .wdata_i(m_wd), .rdata_o(m0_rd));
  gtb_ram #(.WIDTH(MAX_COLS), .DEPTH(2**RB)) u_mark1 (
    .clk_i, .addr_i(m_addr), .we_i(m1_we), .re_i(m_re), .wdata_i(m_wd), .rdata_o(m1_rd));

  logic [SZ_W-1:0] nr_m1, nc_m1;
  logic [RB-1:0]   cr, sr, nbr;
  logic [CB-1:0]   cc, sc, nbc;
  logic            nb_ok, accept, take;
  logic [SZ_W:0]   seed_row;

  assign nr_m1    = size_i.nr - SZ_W'(1);
  assign nc_m1    = size_i.nc - SZ_W'(1);
  assign cr       = cur_q[AW-1:CB];
  assign cc       = cur_q[CB-1:0];
  assign mrow     = f_q ? m1_rd : m0_rd;
  assign accept   = in_valid_i && in_ready_o;
  assign seed_row = cnt_q - (SZ_W+1)'(size_i.nc);

  // seed target: columns of the first or last row, then rows of the first or last column
  always_comb begin
    if (cnt_q < (SZ_W+1)'(size_i.nc)) begin
      sc = cnt_q[CB-1:0];
      sr = f_q ? nr_m1[RB-1:0] : '0;
    end else begin
      sr = seed_row[RB-1:0];
      sc = f_q ? nc_m1[CB-1:0] : '0;
    end
  end

  always_comb begin
    nbr   = cr;
    nbc   = cc;
    nb_ok = 1'b0;
    unique case (d_q)
      2'd0: begin nb_ok = (cr != '0); nbr = cr - RB'(1); end
      2'd1: begin nb_ok = (SZ_W'(cc) + SZ_W'(1) < size_i.nc); nbc = cc + CB'(1); end
      2'd2: begin nb_ok = (SZ_W'(cr) + SZ_W'(1) < size_i.nr); nbr = cr + RB'(1); end
      default: begin nb_ok = (cc != '0); nbc = cc - CB'(1); end
    endcase
  end

  // mark and enqueue when unmarked (and high enough, for a neighbour)
  assign take = !mrow[tc_q] && ((state_q == S_SEED_W) || (h_rd >= h_q));

  assign in_ready_o  = (state_q == S_LOAD);
  assign res_valid_o = (state_q == S_OUT_W);
  assign res_o.row   = ROW_W'(cnt_q);
  assign res_o.mask  = m0_rd & m1_rd;
  assign res_o.last  = (cnt_q == (SZ_W+1)'(nr_m1));

  always_comb begin
    h_addr = {lr_q, lc_q};
    h_we   = 1'b0;
    h_re   = 1'b0;
    h_wd   = in_height_i;
    q_addr = tail_q[AW-1:0];
    q_we   = 1'b0;
    q_re   = 1'b0;
    q_wd   = {tr_q, tc_q};
    m_addr = tr_q;
    m_re   = 1'b0;
    m0_we  = 1'b0;
    m1_we  = 1'b0;
    m_wd   = mrow | (MAX_COLS'(1) << tc_q);
    unique case (state_q)
      S_LOAD: h_we = accept;
      S_CLR: begin
        m_addr = cnt_q[RB-1:0];
        m_wd   = '0;
        m0_we  = !f_q;
        m1_we  = f_q;
      end
      S_SEED_R: begin m_addr = sr; m_re = 1'b1; end
      S_SEED_W, S_NB_W: begin
        m0_we = take && !f_q;
        m1_we = take && f_q;
        q_we  = take;
      end
      S_POP: begin q_addr = head_q[AW-1:0]; q_re = (head_q != tail_q); end
      S_POP_W: begin h_addr = q_rd; h_re = 1'b1; end
      S_NB_R: begin
        m_addr = nbr;
        h_addr = {nbr, nbc};
        m_re   = nb_ok;
        h_re   = nb_ok;
      end
      S_OUT_R: begin m_addr = cnt_q[RB-1:0]; m_re = 1'b1; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      f_q     <= 1'b0;
      lr_q    <= '0;
      lc_q    <= '0;
      cnt_q   <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      cur_q   <= '0;
      h_q     <= '0;
      tr_q    <= '0;
      tc_q    <= '0;
      d_q     <= '0;
    end else begin
      unique case (state_q)
        S_LOAD: begin
          if (size_i.restart) begin
            lr_q <= '0;
            lc_q <= '0;
          end else if (accept) begin
            if (SZ_W'(lc_q) == nc_m1) begin
              lc_q <= '0;
              if (SZ_W'(lr_q) == nr_m1) begin
                lr_q    <= '0;
                f_q     <= 1'b0;
                cnt_q   <= '0;
                state_q <= S_CLR;
              end else begin
                lr_q <= lr_q + RB'(1);
              end
            end else begin
              lc_q <= lc_q + CB'(1);
            end
          end
        end
        S_CLR: begin
          if (cnt_q == (SZ_W+1)'(nr_m1)) begin
            cnt_q   <= '0;
            head_q  <= '0;
            tail_q  <= '0;
            state_q <= S_SEED_R;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_SEED_R: begin
          if (cnt_q == (SZ_W+1)'(size_i.nr) + (SZ_W+1)'(size_i.nc)) begin
            state_q <= S_POP;
          end else begin
            tr_q    <= sr;
            tc_q    <= sc;
            state_q <= S_SEED_W;
          end
        end
        S_SEED_W: begin
          if (take) tail_q <= tail_q + 1'b1;
          cnt_q   <= cnt_q + 1'b1;
          state_q <= S_SEED_R;
        end
        S_POP: begin
          cnt_q <= '0;
          if (head_q == tail_q) begin
            if (!f_q) begin
              f_q     <= 1'b1;
              state_q <= S_CLR;
            end else begin
              state_q <= S_OUT_R;
            end
          end else begin
            head_q  <= head_q + 1'b1;
            state_q <= S_POP_W;
          end
        end
        S_POP_W: begin
          cur_q   <= q_rd;
          state_q <= S_HGT_W;
        end
        S_HGT_W: begin
          h_q     <= h_rd;
          d_q     <= '0;
          state_q <= S_NB_R;
        end
        S_NB_R: begin
          if (nb_ok) begin
            tr_q    <= nbr;
            tc_q    <= nbc;
            state_q <= S_NB_W;
          end else if (d_q == 2'd3) begin
            state_q <= S_POP;
          end else begin
            d_q <= d_q + 2'd1;
          end
        end
        S_NB_W: begin
          if (take) tail_q <= tail_q + 1'b1;
          if (d_q == 2'd3) begin
            state_q <= S_POP;
          end else begin
            d_q     <= d_q + 2'd1;
            state_q <= S_NB_R;
          end
        end
        S_OUT_R: state_q <= S_OUT_W;
        S_OUT_W: begin
          if (res_ready_i) begin
            if (res_o.last) begin
              cnt_q   <= '0;
              state_q <= S_LOAD;
            end else begin
              cnt_q   <= cnt_q + 1'b1;
              state_q <= S_OUT_R;
            end
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

endmodule

[rtl/grid_two_border_flood_reach.sv]
// ----------------------------------------------------------------------------
// grid_two_border_flood_reach
// Top level: size registers, flood engine and the result output register.
// ----------------------------------------------------------------------------
// Heights load one item per cycle in row-major order into a grid of
// rows_in_use x cols_in_use cells (a size of zero reads as one, oversize
// saturates at 32). Writing either size register restarts the load at cell
// (0,0). After the last cell the input stalls while two floods run, each
// preceded by a clearing pass over the rows_in_use rows of its mark memory
// and a seeding pass over its border cells; each queued cell then steps
// through pop, height read and neighbour checks on the single-port height,
// mark and queue memories. One result per row follows, with tlast on the
// final row; the input reopens once the final row enters the output register.
module grid_two_border_flood_reach
  import gtb_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [HEIGHT_BITS-1:0] s_axis_tdata_i,  // height
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [TDATA_O_W-1:0]   m_axis_tdata_o,  // row_index, both_mask, zero pad
  output logic                   m_axis_tlast_o,  // last_row
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [SZ_W-1:0]        cfg_data_i
);

  logic [SZ_W-1:0] rows_q, cols_q;
  logic            cfg_we;
  size_t           size;
  result_t         res, res_q;
  logic            res_valid, res_ready, m_valid_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= SIZE_RESET;
      cols_q <= SIZE_RESET;
    end else if (cfg_we) begin
      if (cfg_index_i == REG_ROWS) rows_q <= cfg_data_i;
      if (cfg_index_i == REG_COLS) cols_q <= cfg_data_i;
    end
  end

  assign size.nr      = eff_size(rows_q, SZ_W'(MAX_ROWS));
  assign size.nc      = eff_size(cols_q, SZ_W'(MAX_COLS));
  assign size.restart = cfg_we && (cfg_index_i == REG_ROWS || cfg_index_i == REG_COLS);

  gtb_engine u_engine (
    .clk_i,
    .rst_ni,
    .size_i      (size),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_height_i (s_axis_tdata_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !m_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_ready) begin
      m_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) res_q <= res;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = TDATA_O_W'({res_q.mask, res_q.row});
  assign m_axis_tlast_o  = res_q.last;

endmodule

[rtl/gtb_checker.sv]
// ----------------------------------------------------------------------------
// gtb_checker
// Port-level checks of the flood block, bound to the top level.
// ----------------------------------------------------------------------------
module gtb_checker
  import gtb_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid_i,
  input logic                 s_axis_tready_o,
  input logic                 m_axis_tvalid_o,
  input logic                 m_axis_tready_i,
  input logic [TDATA_O_W-1:0] m_axis_tdata_o,
  input logic                 m_axis_tlast_o
);

  // the load closes only on an accepted item
  a_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready_o) |-> $past(s_axis_tvalid_i))
    else $error("input closed without an accepted item");

  // the load reopens only when the final row is on offer
  a_reopen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s_axis_tready_o) |-> m_axis_tvalid_o && m_axis_tlast_o)
    else $error("input reopened before the final row");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled result changed");

endmodule

bind grid_two_border_flood_reach gtb_checker u_gtb_checker (
  .clk_i,
  .rst_ni,
  .s_axis_tvalid_i,
  .s_axis_tready_o,
  .m_axis_tvalid_o,
  .m_axis_tready_i,
  .m_axis_tdata_o,
  .m_axis_tlast_o
);
